// ----- hw/rtl/fhud_pkg.sv -----
// Package for the fixed-header unit deframer.
// Holds header layout constants and the result record type.
// No dependencies.
package fhud_pkg;

  localparam int unsigned HdrBytesDef = 128;
  localparam int unsigned HdrBytesMin = 16;

  // Header field offsets, little endian.
  localparam int unsigned OfsKind = 4;
  localparam int unsigned OfsTs   = 8;
  localparam int unsigned OfsEnd  = 16;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_data;
    logic [31:0] unit_kind;
    logic [63:0] unit_timestamp;
    logic [31:0] unit_length;
    logic        first_of_unit;
    logic        last_of_unit;
  } res_t;

endpackage

// ----- hw/rtl/fixed_header_unit_deframer.sv -----
// Fixed-header unit deframer: one raw byte in per transfer, at most one result out.
// A result is registered in the output stage, or in the skid stage under output stall.
// Throughput: one byte per cycle while the skid stage is empty; the header counter
// and payload down-counter update per transfer; the skid absorbs one stalled result.
// Reset (rst_ni low, asynchronous): header expected next, all field registers zero,
// output and skid stages empty.
module fixed_header_unit_deframer #(
  parameter int unsigned HEADER_BYTES = fhud_pkg::HdrBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        has_data_o,
  output logic [31:0] unit_kind_o,
  output logic [63:0] unit_timestamp_o,
  output logic [31:0] unit_length_o,
  output logic        first_of_unit_o,
  output logic        last_of_unit_o
);
  import fhud_pkg::*;

  logic take;
  logic push;
  logic full;
  res_t res_new;
  res_t res_out;

  // A byte transfer completes whenever the skid stage is empty; the skid
  // guarantees room for the result that transfer may create.
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  // Header parse and payload counting
  fhud_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .byte_i(byte_in_i),
    .push_o(push),
    .res_o (res_new)
  );

  // Result register plus skid
  fhud_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res_new),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign payload_byte_o   = res_out.payload_byte;
  assign has_data_o       = res_out.has_data;
  assign unit_kind_o      = res_out.unit_kind;
  assign unit_timestamp_o = res_out.unit_timestamp;
  assign unit_length_o    = res_out.unit_length;
  assign first_of_unit_o  = res_out.first_of_unit;
  assign last_of_unit_o   = res_out.last_of_unit;

endmodule

// ----- hw/rtl/fhud_core.sv -----
// Deframer core: header capture, payload count and result build.
// Depends on fhud_pkg.
module fhud_core #(
  parameter int unsigned HEADER_BYTES = fhud_pkg::HdrBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  output logic          push_o,
  output fhud_pkg::res_t res_o
);
  import fhud_pkg::*;

  // wide enough to hold the header size itself, so the field offsets never wrap
  localparam int unsigned PosW = $clog2(HEADER_BYTES + 1);
  localparam logic [PosW-1:0] PosLast = PosW'(HEADER_BYTES - 1);

  logic            in_payload_q, in_payload_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     length_q, length_d;
  logic [31:0]     kind_q, kind_d;
  logic [63:0]     ts_q, ts_d;
  logic [31:0]     left_q, left_d;
  logic            emit_data;

  assign emit_data = in_payload_q && (left_q != 32'd0);

  always_comb begin
    in_payload_d = in_payload_q;
    pos_d        = pos_q;
    length_d     = length_q;
    kind_d       = kind_q;
    ts_d         = ts_q;
    left_d       = left_q;
    push_o       = 1'b0;
    res_o        = '0;

    if (emit_data) begin
      push_o              = take_i;
      res_o.payload_byte  = byte_i;
      res_o.has_data      = 1'b1;
      res_o.unit_kind     = kind_q;
      res_o.unit_timestamp = ts_q;
      res_o.unit_length   = length_q;
      res_o.first_of_unit = (left_q == length_q);
      res_o.last_of_unit  = (left_q == 32'd1);
      left_d              = left_q - 32'd1;
      if (left_q == 32'd1) begin
        in_payload_d = 1'b0;
      end
    end else begin
      in_payload_d = 1'b0;
      if (pos_q < PosW'(OfsKind)) begin
        length_d[8*pos_q[1:0] +: 8] = byte_i;
      end else if (pos_q < PosW'(OfsTs)) begin
        kind_d[8*pos_q[1:0] +: 8] = byte_i;
      end else if (pos_q < PosW'(OfsEnd)) begin
        ts_d[8*pos_q[2:0] +: 8] = byte_i;
      end

      if (pos_q == PosLast) begin
        pos_d = '0;
        if (length_d == 32'd0) begin
          // empty payload: single marker result
          push_o               = take_i;
          res_o.has_data       = 1'b0;
          res_o.unit_kind      = kind_d;
          res_o.unit_timestamp = ts_d;
          res_o.unit_length    = length_d;
          res_o.first_of_unit  = 1'b1;
          res_o.last_of_unit   = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          left_d       = length_d;
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      pos_q        <= '0;
      length_q     <= '0;
      kind_q       <= '0;
      ts_q         <= '0;
      left_q       <= '0;
    end else if (take_i) begin
      in_payload_q <= in_payload_d;
      pos_q        <= pos_d;
      length_q     <= length_d;
      kind_q       <= kind_d;
      ts_q         <= ts_d;
      left_q       <= left_d;
    end
  end

endmodule

// ----- hw/rtl/fhud_out_reg.sv -----
// Output register with a skid stage; stall to the input is registered.
// Depends on fhud_pkg.
module fhud_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fhud_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fhud_pkg::res_t res_o
);
  import fhud_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
